// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is applied.
`define PSE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Concurrent assertion that is also checked during reset.
`define PSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// ----- sv/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// Types and constants of the postfix stack evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

	localparam int WORD_W   = 32;
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [WORD_W-1:0]   word_t;

	// Token kinds.
	localparam func_t FUNC_PUSH = 3'd0;
	localparam func_t FUNC_ADD  = 3'd1;
	localparam func_t FUNC_SUB  = 3'd2;
	localparam func_t FUNC_MUL  = 3'd3;
	localparam func_t FUNC_DIV  = 3'd4;

	// Result status codes.
	localparam status_t STAT_OK   = 2'd0;
	localparam status_t STAT_FULL = 2'd1;
	localparam status_t STAT_FEW  = 2'd2;
	localparam status_t STAT_DIV0 = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_EXEC,
		S_WAIT,
		S_POPRD,
		S_TOPLD,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    in_ready;
		logic    capture;
		logic    stat_wr;
		status_t stat_val;
		logic    push;
		logic    rd_below;
		logic    start_md;
		logic    wr_result;
		logic    res_md;
		logic    pop2;
		logic    load_top;
		logic    emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		func_t func;
		logic  full;
		logic  few;
		logic  b_zero;
		logic  md_done;
		logic  out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- sv/pse_in_if.sv -----
// ----------------------------------------------------------------------------
// pse_in_if
// Token channel: valid/ready handshake carrying one token per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pse_in_if;
	logic                valid;
	logic                ready;
	logic [2:0]          func;
	logic signed [31:0]  number;

	modport source (output valid, output func, output number, input ready);
	modport sink (input valid, input func, input number, output ready);
endinterface

`default_nettype wire

// ----- sv/pse_out_if.sv -----
// ----------------------------------------------------------------------------
// pse_out_if
// Result channel: valid/ready handshake carrying status, top and depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pse_out_if #(
	parameter int DEPTH_W = 3
);
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic signed [31:0]  top_value;
	logic [DEPTH_W-1:0]  depth;

	modport source (output valid, output status, output top_value, output depth, input ready);
	modport sink (input valid, input status, input top_value, input depth, output ready);
endinterface

`default_nettype wire

// ----- sv/postfix_stack_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// Postfix integer evaluator on a bounded stack of signed 32-bit entries.
// ----------------------------------------------------------------------------
// Usage:
//   tok carries one token per request: func selects push, add, subtract,
//   multiply or divide, and number is the value pushed. res returns one
//   result per token: status, the new top of stack (zero when empty) and
//   the depth. Both channels use valid/ready; a request moves when both
//   are high at a rising edge of clk.
//   A push, an unused token kind or a rejected token goes from decode
//   straight to the response; add and subtract first read the entry
//   below the top and then execute; multiply and divide also wait for the
//   shared multiply/divide unit, which retires one bit per cycle, and a
//   divide by zero pops both operands and reloads the top from memory.
//   One token is worked on at a time; tok.ready rises again in the same
//   cycle as the result is loaded into the output register.
//   A stalled receiver holds the result in the output register; the next
//   token is still taken and worked on, but its result waits until the
//   output register is free.
//   arst_n empties the stack and drops any pending result; stack memory
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_evaluator_core #(
	parameter int STACK_DEPTH = 5
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pse_in_if.sink    tok,
	pse_out_if.source res
);
	pse_pkg::cmd_t cmd;
	pse_pkg::sts_t sts;

	pse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	pse_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.tok    (tok),
		.res    (res)
	);

endmodule

`default_nettype wire

// ----- sv/pse_muldiv.sv -----
// ----------------------------------------------------------------------------
// pse_muldiv
// Shared iterative unit: shift-add multiply (low word) and restoring signed
// divide truncating toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pse_muldiv (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          is_div,
	input  wire pse_pkg::word_t a,
	input  wire pse_pkg::word_t b,
	output logic               done,
	output pse_pkg::word_t     result
);
	localparam int W     = pse_pkg::WORD_W;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             fin_q;
	logic             div_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     x_q;
	logic [W-1:0]     y_q;
	logic [W:0]       acc_q;
	logic [W-1:0]     mag_a;
	logic [W-1:0]     mag_b;
	logic [W:0]       rem_sh;
	logic [W:0]       diff;

	always_comb begin
		mag_a  = a[W-1] ? (~a + 1'b1) : a;
		mag_b  = b[W-1] ? (~b + 1'b1) : b;
		rem_sh = {acc_q[W-1:0], x_q[W-1]};
		diff   = rem_sh - {1'b0, y_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// In a divide x_q holds the dividend that shifts into the remainder
	// while the quotient bits shift in behind it.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= a[W-1] ^ b[W-1];
			acc_q <= '0;
			x_q   <= is_div ? mag_a : a;
			y_q   <= is_div ? mag_b : b;
		end else if (busy_q) begin
			if (div_q) begin
				if (!diff[W]) begin
					acc_q <= diff;
					x_q   <= {x_q[W-2:0], 1'b1};
				end else begin
					acc_q <= rem_sh;
					x_q   <= {x_q[W-2:0], 1'b0};
				end
			end else begin
				if (y_q[0]) begin
					acc_q <= {1'b0, acc_q[W-1:0] + x_q};
				end
				x_q <= {x_q[W-2:0], 1'b0};
				y_q <= {1'b0, y_q[W-1:1]};
			end
		end
	end

	assign done   = fin_q;
	assign result = div_q ? (neg_q ? (~x_q + 1'b1) : x_q) : acc_q[W-1:0];

endmodule

`default_nettype wire

// ----- sv/pse_ctrl.sv -----
// ----------------------------------------------------------------------------
// pse_ctrl
// Controller state machine sequencing one token through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pse_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tok_valid,
	input  wire pse_pkg::sts_t sts,
	output pse_pkg::cmd_t      cmd
);
	pse_pkg::state_t state_q;
	pse_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			pse_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (tok_valid) begin
					cmd.capture  = 1'b1;
					cmd.stat_wr  = 1'b1;
					cmd.stat_val = pse_pkg::STAT_OK;
					state_nxt    = pse_pkg::S_DECODE;
				end
			end
			pse_pkg::S_DECODE: begin
				state_nxt = pse_pkg::S_RESP;
				case (sts.func)
					pse_pkg::FUNC_PUSH: begin
						if (sts.full) begin
							cmd.stat_wr  = 1'b1;
							cmd.stat_val = pse_pkg::STAT_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end
					pse_pkg::FUNC_ADD, pse_pkg::FUNC_SUB,
					pse_pkg::FUNC_MUL, pse_pkg::FUNC_DIV: begin
						if (sts.few) begin
							cmd.stat_wr  = 1'b1;
							cmd.stat_val = pse_pkg::STAT_FEW;
						end else begin
							state_nxt = pse_pkg::S_READ;
						end
					end
					default: begin
						// Unused token kinds leave the stack alone.
						state_nxt = pse_pkg::S_RESP;
					end
				endcase
			end
			pse_pkg::S_READ: begin
				cmd.rd_below = 1'b1;
				state_nxt    = pse_pkg::S_EXEC;
			end
			pse_pkg::S_EXEC: begin
				case (sts.func)
					pse_pkg::FUNC_MUL: begin
						cmd.start_md = 1'b1;
						state_nxt    = pse_pkg::S_WAIT;
					end
					pse_pkg::FUNC_DIV: begin
						if (sts.b_zero) begin
							cmd.pop2     = 1'b1;
							cmd.stat_wr  = 1'b1;
							cmd.stat_val = pse_pkg::STAT_DIV0;
							state_nxt    = pse_pkg::S_POPRD;
						end else begin
							cmd.start_md = 1'b1;
							state_nxt    = pse_pkg::S_WAIT;
						end
					end
					default: begin
						cmd.wr_result = 1'b1;
						state_nxt     = pse_pkg::S_RESP;
					end
				endcase
			end
			pse_pkg::S_WAIT: begin
				if (sts.md_done) begin
					cmd.wr_result = 1'b1;
					cmd.res_md    = 1'b1;
					state_nxt     = pse_pkg::S_RESP;
				end
			end
			pse_pkg::S_POPRD: begin
				// The new top sits one below the reduced count.
				state_nxt = pse_pkg::S_TOPLD;
			end
			pse_pkg::S_TOPLD: begin
				cmd.load_top = 1'b1;
				state_nxt    = pse_pkg::S_RESP;
			end
			pse_pkg::S_RESP: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = pse_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = pse_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/pse_datapath.sv -----
// ----------------------------------------------------------------------------
// pse_datapath
// Stack memory, cached top of stack, entry count, adder and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pse_datapath #(
	parameter int STACK_DEPTH = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pse_pkg::cmd_t cmd,
	output pse_pkg::sts_t      sts,
	pse_in_if.sink             tok,
	pse_out_if.source          res
);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	pse_pkg::word_t   mem_q [STACK_DEPTH];
	pse_pkg::word_t   rd_q;
	pse_pkg::word_t   top_q;
	pse_pkg::word_t   num_q;
	pse_pkg::func_t   func_q;
	pse_pkg::status_t stat_q;
	logic [CW-1:0]    count_q;

	logic             out_valid_q;
	pse_pkg::status_t out_status_q;
	pse_pkg::word_t   out_top_q;
	logic [CW-1:0]    out_depth_q;

	logic [CW-1:0]    cnt_m1;
	logic [CW-1:0]    cnt_m2;
	logic [CW-1:0]    rd_addr;
	pse_pkg::word_t   add_sub;
	pse_pkg::word_t   alu_res;
	pse_pkg::word_t   md_result;
	logic             md_done;

	always_comb begin
		cnt_m1  = count_q - CW'(1);
		cnt_m2  = count_q - CW'(2);
		rd_addr = cmd.rd_below ? cnt_m2 : cnt_m1;
		add_sub = (func_q == pse_pkg::FUNC_SUB) ? (rd_q - top_q) : (rd_q + top_q);
		alu_res = cmd.res_md ? md_result : add_sub;
	end

	pse_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_md),
		.is_div (func_q == pse_pkg::FUNC_DIV),
		.a      (rd_q),
		.b      (top_q),
		.done   (md_done),
		.result (md_result)
	);

	// Stack memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[count_q[AW-1:0]] <= num_q;
		end else if (cmd.wr_result) begin
			mem_q[cnt_m2[AW-1:0]] <= alu_res;
		end
		rd_q <= mem_q[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= tok.func;
			num_q  <= tok.number;
		end
		if (cmd.stat_wr) begin
			stat_q <= cmd.stat_val;
		end
		if (cmd.push) begin
			top_q <= num_q;
		end else if (cmd.wr_result) begin
			top_q <= alu_res;
		end else if (cmd.load_top) begin
			top_q <= rd_q;
		end
		if (cmd.emit) begin
			out_status_q <= stat_q;
			out_top_q    <= (count_q != '0) ? top_q : '0;
			out_depth_q  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.wr_result) begin
				count_q <= cnt_m1;
			end else if (cmd.pop2) begin
				count_q <= cnt_m2;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.func     = func_q;
		sts.full     = (count_q == CW'(STACK_DEPTH));
		sts.few      = (count_q < CW'(2));
		sts.b_zero   = (top_q == '0);
		sts.md_done  = md_done;
		sts.out_free = !out_valid_q || res.ready;
	end

	assign tok.ready     = cmd.in_ready;
	assign res.valid     = out_valid_q;
	assign res.status    = out_status_q;
	assign res.top_value = $signed(out_top_q);
	assign res.depth     = out_depth_q;

endmodule

`default_nettype wire

// ----- sv/pse_checker.sv -----
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks of the postfix stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pse_checker #(
	parameter int STACK_DEPTH = 5
) (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  tok_valid,
	input wire logic                                  tok_ready,
	input wire logic                                  res_valid,
	input wire logic                                  res_ready,
	input wire logic [1:0]                            res_status,
	input wire logic [31:0]                           res_top_value,
	input wire logic [$clog2(STACK_DEPTH + 1)-1:0]    res_depth
);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	`PSE_ASSERT(a_depth_bound, clk, arst_n, res_valid |-> (res_depth <= DW'(STACK_DEPTH)), "depth beyond stack size")
	`PSE_ASSERT(a_empty_top, clk, arst_n, (res_valid && res_depth == '0) |-> (res_top_value == '0), "empty stack shows a nonzero top")
	`PSE_ASSERT(a_full_depth, clk, arst_n, (res_valid && res_status == pse_pkg::STAT_FULL) |-> (res_depth == DW'(STACK_DEPTH)), "push dropped on a stack that is not full")
	`PSE_ASSERT(a_one_token, clk, arst_n, (tok_valid && tok_ready) |=> !tok_ready, "second token taken while one is in work")
	`PSE_ASSERT(a_res_hold, clk, arst_n, (res_valid && !res_ready) |=> (res_valid && $stable(res_status) && $stable(res_depth)), "stalled result changed")

endmodule

bind postfix_stack_evaluator_core pse_checker #(
	.STACK_DEPTH (STACK_DEPTH)
) u_pse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tok_valid     (tok.valid),
	.tok_ready     (tok.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_status    (res.status),
	.res_top_value (res.top_value),
	.res_depth     (res.depth)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the postfix stack evaluator. A token stream of
// pushes, operators and unused codes goes in with random gaps, and results
// are taken with random stalls. Every result is checked against a local
// model of the stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int             STACK_DEPTH  = 5;
	localparam int             MIN_OPERANDS = 2;
	localparam int             MAX_IDLE     = 18;
	localparam int             RESET_CYCLES = 4;
	localparam int             DRAIN_CYCLES = 60;
	localparam int             IDLE_LIMIT   = 2000;
	localparam pse_pkg::func_t FUNC_MAX     = '1;
	localparam pse_pkg::word_t WORD_MIN     = 32'h8000_0000;
	localparam pse_pkg::word_t WORD_MAX     = 32'h7FFF_FFFF;
	localparam pse_pkg::word_t WORD_ONES    = 32'hFFFF_FFFF;

	typedef struct packed {
		pse_pkg::status_t status;
		pse_pkg::word_t   top_value;
		logic [2:0]       depth;
	} stack_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pse_in_if  tok ();
	pse_out_if #(.DEPTH_W(3)) res ();

	postfix_stack_evaluator_core #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.tok(tok),
		.res(res)
	);

	always #4 clk = ~clk;

	pse_pkg::word_t model_stack [STACK_DEPTH];
	int unsigned    model_depth = 0;
	stack_view_t    expected_views [$];
	bit             quiet = 1'b0;
	int unsigned    error_count = 0;
	int unsigned    tokens_sent = 0;
	int unsigned    results_checked = 0;
	int unsigned    status_seen [4] = '{default: 0};

	// Applies one accepted token to the model stack and queues the view that
	// the block must report afterwards.
	task automatic evaluate_token(input pse_pkg::func_t f, input pse_pkg::word_t num);
		stack_view_t    view;
		pse_pkg::word_t a, b, r, ma, mb;
		view.status = pse_pkg::STAT_OK;
		r = '0;
		if (f == pse_pkg::FUNC_PUSH) begin
			if (model_depth < STACK_DEPTH) begin
				model_stack[model_depth] = num;
				model_depth++;
			end else begin
				view.status = pse_pkg::STAT_FULL;
			end
		end else if (f <= pse_pkg::FUNC_DIV) begin
			if (model_depth < MIN_OPERANDS) begin
				view.status = pse_pkg::STAT_FEW;
			end else begin
				b = model_stack[model_depth - 1];
				a = model_stack[model_depth - 2];
				model_depth -= 2;
				case (f)
					pse_pkg::FUNC_ADD: r = a + b;
					pse_pkg::FUNC_SUB: r = a - b;
					pse_pkg::FUNC_MUL: r = a * b;
					default: begin
						if (b == '0) begin
							view.status = pse_pkg::STAT_DIV0;
						end else begin
							// Divide magnitudes, then fix the sign: truncates
							// toward zero and lets the most negative value
							// over minus one wrap back to itself.
							ma = a[31] ? -a : a;
							mb = b[31] ? -b : b;
							r  = ma / mb;
							if (a[31] != b[31])
								r = -r;
						end
					end
				endcase
				if (view.status == pse_pkg::STAT_OK) begin
					model_stack[model_depth] = r;
					model_depth++;
				end
			end
		end
		view.top_value = (model_depth != 0) ? model_stack[model_depth - 1] : '0;
		view.depth     = 3'(model_depth);
		expected_views.push_back(view);
	endtask

	task automatic send_token(input pse_pkg::func_t f, input pse_pkg::word_t num);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			tok.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok.valid  <= 1'b1;
		tok.func   <= f;
		tok.number <= num;
		@(posedge clk);
		while (!tok.ready)
			@(posedge clk);
		evaluate_token(f, num);
		tokens_sent++;
	endtask

	task automatic check_view();
		stack_view_t want;
		if (expected_views.size() == 0) begin
			$display("%0t: unexpected result: status %0d top %0d depth %0d", $time,
				res.status, res.top_value, res.depth);
			error_count++;
		end else begin
			want = expected_views.pop_front();
			if (res.status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d", $time,
					want.status, res.status);
				error_count++;
			end
			if (res.top_value !== want.top_value) begin
				$display("%0t: top mismatch: expected %0d, actual %0d", $time,
					$signed(want.top_value), res.top_value);
				error_count++;
			end
			if (res.depth !== want.depth) begin
				$display("%0t: depth mismatch: expected %0d, actual %0d", $time,
					want.depth, res.depth);
				error_count++;
			end
			results_checked++;
			status_seen[want.status]++;
		end
	endtask

	// Operands lean towards small values and the extremes, so that division by
	// zero, sign handling and wrap-around come up often.
	function automatic pse_pkg::word_t rand_operand();
		case ($urandom_range(0, 9))
			4, 5, 6: return pse_pkg::word_t'($urandom_range(0, 16)) - 32'd8;
			7:       return $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
			8:       return $urandom_range(0, 1) ? WORD_ONES
				: pse_pkg::word_t'($urandom_range(0, 1));
			9:       return pse_pkg::word_t'(1) << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	task automatic test_short_stack();
		send_token(pse_pkg::FUNC_ADD, $urandom());
		send_token(pse_pkg::FUNC_SUB, $urandom());
		send_token(pse_pkg::FUNC_PUSH, 32'd7);
		send_token(pse_pkg::FUNC_MUL, $urandom());
		send_token(pse_pkg::FUNC_DIV, $urandom());
		for (int f = pse_pkg::FUNC_DIV + 1; f <= FUNC_MAX; f++)
			send_token(pse_pkg::func_t'(f), $urandom());
	endtask

	task automatic test_full_stack();
		send_token(pse_pkg::FUNC_PUSH, WORD_MAX);
		send_token(pse_pkg::FUNC_PUSH, WORD_MIN);
		send_token(pse_pkg::FUNC_PUSH, '0);
		send_token(pse_pkg::FUNC_PUSH, WORD_ONES);
		send_token(pse_pkg::FUNC_PUSH, 32'hA5A5_5A5A);
	endtask

	task automatic test_arithmetic();
		send_token(pse_pkg::FUNC_DIV, $urandom());
		send_token(pse_pkg::FUNC_DIV, $urandom());
		send_token(pse_pkg::FUNC_PUSH, WORD_MIN);
		send_token(pse_pkg::FUNC_PUSH, WORD_ONES);
		send_token(pse_pkg::FUNC_DIV, $urandom());
		send_token(pse_pkg::FUNC_ADD, $urandom());
		send_token(pse_pkg::FUNC_MUL, $urandom());
		send_token(pse_pkg::FUNC_PUSH, 32'd2);
		send_token(pse_pkg::FUNC_DIV, $urandom());
		send_token(pse_pkg::FUNC_PUSH, WORD_MIN);
		send_token(pse_pkg::FUNC_SUB, $urandom());
		send_token(pse_pkg::FUNC_PUSH, -32'sd5);
		send_token(pse_pkg::FUNC_DIV, $urandom());
	endtask

	// Mostly well-formed expressions: pushes are favoured on a shallow stack
	// and operators on a deep one, with a few unused codes mixed in.
	task automatic test_random_tokens(input int unsigned count, input bit no_idle);
		int unsigned sel, push_weight;
		quiet = no_idle;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			push_weight = 50;
			if (model_depth < MIN_OPERANDS)
				push_weight = 80;
			else if (model_depth == STACK_DEPTH)
				push_weight = 15;
			if (sel < 4)
				send_token(pse_pkg::func_t'($urandom_range(pse_pkg::FUNC_DIV + 1, FUNC_MAX)),
					$urandom());
			else if (sel < push_weight)
				send_token(pse_pkg::FUNC_PUSH, rand_operand());
			else
				send_token(pse_pkg::func_t'($urandom_range(pse_pkg::FUNC_ADD,
					pse_pkg::FUNC_DIV)), $urandom());
		end
		quiet = 1'b0;
	endtask

	initial begin : result_sink
		int unsigned stall;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall == 0) begin
				res.ready <= 1'b1;
			end else begin
				res.ready <= 1'b0;
				@(posedge clk);
				while (!res.valid)
					@(posedge clk);
				repeat (stall - 1) @(posedge clk);
				res.ready <= 1'b1;
			end
			@(posedge clk);
			while (!(res.valid && res.ready))
				@(posedge clk);
			check_view();
		end
	end

	initial begin : watchdog
		int unsigned still;
		still = 0;
		while (still < IDLE_LIMIT) begin
			@(posedge clk);
			if ((tok.valid && tok.ready) || (res.valid && res.ready))
				still = 0;
			else
				still++;
		end
		$display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : run
		tok.valid  <= 1'b0;
		tok.func   <= pse_pkg::FUNC_PUSH;
		tok.number <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_stack();
		test_full_stack();
		test_arithmetic();
		test_random_tokens(400, 1'b0);
		test_random_tokens(150, 1'b1);
		test_random_tokens(400, 1'b0);
		test_random_tokens(60, 1'b1);
		tok.valid <= 1'b0;

		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Evaluated %0d tokens and checked %0d results.", tokens_sent, results_checked);
		$display("Status counts: ok %0d, stack full %0d, too few operands %0d, divide by zero %0d.",
			status_seen[pse_pkg::STAT_OK], status_seen[pse_pkg::STAT_FULL],
			status_seen[pse_pkg::STAT_FEW], status_seen[pse_pkg::STAT_DIV0]);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/pse_pkg.sv
sv/pse_in_if.sv
sv/pse_out_if.sv
sv/pse_muldiv.sv
sv/pse_ctrl.sv
sv/pse_datapath.sv
sv/postfix_stack_evaluator_core.sv
sv/pse_checker.sv
tb/sv/testbench.sv
